// ===== hdl/obav_pkg.sv =====
// ----------------------------------------------------------------------------
// obav_pkg - shared types and constants for the obstacle avoid navigator
// Payload structs, motor command codes, pan angles and register indexes.
// ----------------------------------------------------------------------------
package obav_pkg;

    // distance and timing widths
    localparam int unsigned TIME_W = 32;
    localparam int unsigned DIST_W = 10;
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned DUTY_W = 8;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned PAN_W  = 8;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned MODE_W = 2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAFE_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DURATION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_DURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_LIMIT   = 3'd7;

    // register reset values
    localparam logic [DIST_W-1:0] RST_SAFE_DISTANCE   = 10'd22;
    localparam logic [DUR_W-1:0]  RST_SCAN_PERIOD     = 16'd400;
    localparam logic [DUR_W-1:0]  RST_TURN_DURATION   = 16'd450;
    localparam logic [DUR_W-1:0]  RST_BACKUP_DURATION = 16'd350;
    localparam logic [DUTY_W-1:0] RST_FORWARD_SPEED   = 8'd180;
    localparam logic [DUTY_W-1:0] RST_TURN_SPEED      = 8'd170;
    localparam logic [DUTY_W-1:0] RST_REVERSE_SPEED   = 8'd160;
    localparam logic [CNT_W-1:0]  RST_BLOCKED_LIMIT   = 4'd3;

    // motor command codes
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REV    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPIN_L = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SPIN_R = 3'd4;

    // pan servo angles in degrees
    localparam logic [PAN_W-1:0] ANGLE_LEFT   = 8'd140;
    localparam logic [PAN_W-1:0] ANGLE_CENTER = 8'd90;
    localparam logic [PAN_W-1:0] ANGLE_RIGHT  = 8'd40;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [DIST_W-1:0] center_cm;
        logic [DIST_W-1:0] left_cm;
        logic [DIST_W-1:0] right_cm;
    } sample_t;

    typedef struct packed {
        logic [CMD_W-1:0]  motor_command;
        logic [DUTY_W-1:0] motor_speed;
        logic [PAN_W-1:0]  pan_angle;
        logic [MODE_W-1:0] nav_mode;
        logic              center_used;
        logic              sides_used;
    } result_t;

endpackage

// ===== hdl/obstacle_avoid_navigator.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_navigator - four-mode obstacle avoiding drive controller
// One control-loop iteration per transaction: mode machine, stuck check,
// motor command, duty and pan angle.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  sample    in         sample_valid/sample_ready  obav_pkg::sample_t
//  result    out        result_valid/result_ready  obav_pkg::result_t
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  one transaction per cycle sustained while result_ready stays high; an
//  accepted sample passes the input register, then the result register
//  all navigation state updates when the input register hands off to the
//  result register, so back-to-back samples see each other's state
//  a stalled result holds the result register and then the input register
//  rst_n clears the mode machine and loads the register defaults at once
//  cfg_ready is always high
//
module obstacle_avoid_navigator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  obav_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output obav_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [obav_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [obav_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [obav_pkg::MODE_W-1:0] {
        MODE_FWD = 2'd0,
        MODE_AVD = 2'd1,
        MODE_TRN = 2'd2,
        MODE_REC = 2'd3
    } mode_t;

    // configuration registers
    logic [obav_pkg::DIST_W-1:0] safe_distance_reg;
    logic [obav_pkg::DUR_W-1:0]  scan_period_reg;
    logic [obav_pkg::DUR_W-1:0]  turn_duration_reg;
    logic [obav_pkg::DUR_W-1:0]  backup_duration_reg;
    logic [obav_pkg::DUTY_W-1:0] forward_speed_reg;
    logic [obav_pkg::DUTY_W-1:0] turn_speed_reg;
    logic [obav_pkg::DUTY_W-1:0] reverse_speed_reg;
    logic [obav_pkg::CNT_W-1:0]  blocked_limit_reg;

    // navigation state
    mode_t                        mode_reg, mode_next;
    logic [obav_pkg::TIME_W-1:0]  last_scan_reg, last_scan_next;
    logic [obav_pkg::TIME_W-1:0]  mode_start_reg, mode_start_next;
    logic                         turn_left_reg, turn_left_next;
    logic [obav_pkg::CNT_W-1:0]   blocked_cnt_reg, blocked_cnt_next;
    logic [obav_pkg::CMD_W-1:0]   motor_reg, motor_next;
    logic [obav_pkg::PAN_W-1:0]   pan_reg, pan_next;

    // pipeline
    logic                         in_valid_reg;
    obav_pkg::sample_t            in_data_reg;
    logic                         out_valid_reg;
    obav_pkg::result_t            out_data_reg, out_data_next;
    logic                         step;

    logic [obav_pkg::TIME_W-1:0]  scan_diff;
    logic [obav_pkg::TIME_W-1:0]  mode_diff;
    logic                         scan_due;
    logic                         blocked;
    logic                         stuck_check;
    logic                         center_used;
    logic                         sides_used;
    logic [obav_pkg::CNT_W-1:0]   cnt_inc;
    logic [obav_pkg::DUTY_W-1:0]  duty;

    assign step         = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || step;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign cfg_ready    = 1'b1;

    assign scan_diff = in_data_reg.time_ms - last_scan_reg;
    assign mode_diff = in_data_reg.time_ms - mode_start_reg;
    assign scan_due  = scan_diff >= {{(obav_pkg::TIME_W-obav_pkg::DUR_W){1'b0}},
                                     scan_period_reg};
    assign blocked   = in_data_reg.center_cm < safe_distance_reg;
    assign cnt_inc   = (blocked_cnt_reg != obav_pkg::CNT_MAX)
                       ? blocked_cnt_reg + 1'b1 : blocked_cnt_reg;

    always_comb
    begin
        mode_next        = mode_reg;
        last_scan_next   = last_scan_reg;
        mode_start_next  = mode_start_reg;
        turn_left_next   = turn_left_reg;
        blocked_cnt_next = blocked_cnt_reg;
        motor_next       = motor_reg;
        pan_next         = pan_reg;
        center_used      = 1'b0;
        sides_used       = 1'b0;

        unique case (mode_reg)
            MODE_FWD:
            begin
                motor_next = obav_pkg::CMD_FWD;
                if (scan_due)
                begin
                    last_scan_next = in_data_reg.time_ms;
                    pan_next       = obav_pkg::ANGLE_CENTER;
                    center_used    = 1'b1;
                    if (blocked)
                    begin
                        mode_next       = MODE_AVD;
                        mode_start_next = in_data_reg.time_ms;
                        motor_next      = obav_pkg::CMD_STOP;
                    end
                end
            end
            MODE_AVD:
            begin
                // the pan sweeps left then right, only the last angle is held
                pan_next        = obav_pkg::ANGLE_RIGHT;
                sides_used      = 1'b1;
                turn_left_next  = in_data_reg.left_cm >= in_data_reg.right_cm;
                mode_next       = MODE_TRN;
                mode_start_next = in_data_reg.time_ms;
            end
            MODE_TRN:
            begin
                motor_next = turn_left_reg ? obav_pkg::CMD_SPIN_L : obav_pkg::CMD_SPIN_R;
                if (mode_diff >= {{(obav_pkg::TIME_W-obav_pkg::DUR_W){1'b0}},
                                  turn_duration_reg})
                begin
                    mode_next       = MODE_FWD;
                    mode_start_next = in_data_reg.time_ms;
                    pan_next        = obav_pkg::ANGLE_CENTER;
                end
            end
            MODE_REC:
            begin
                motor_next = obav_pkg::CMD_REV;
                if (mode_diff >= {{(obav_pkg::TIME_W-obav_pkg::DUR_W){1'b0}},
                                  backup_duration_reg})
                begin
                    mode_next       = MODE_FWD;
                    mode_start_next = in_data_reg.time_ms;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // a forward-mode center check leaves a zero time difference, so from
        // forward the stuck check fires only with a zero scan period
        stuck_check = (mode_next == MODE_FWD) && scan_due &&
                      ((mode_reg != MODE_FWD) || (scan_period_reg == '0));

        if (stuck_check)
        begin
            last_scan_next = in_data_reg.time_ms;
            pan_next       = obav_pkg::ANGLE_CENTER;
            center_used    = 1'b1;
            if (blocked)
            begin
                if (cnt_inc >= blocked_limit_reg)
                begin
                    mode_next        = MODE_REC;
                    mode_start_next  = in_data_reg.time_ms;
                    blocked_cnt_next = '0;
                end
                else
                begin
                    blocked_cnt_next = cnt_inc;
                end
            end
            else if (blocked_cnt_reg != '0)
            begin
                blocked_cnt_next = blocked_cnt_reg - 1'b1;
            end
        end

        unique case (motor_next)
            obav_pkg::CMD_FWD:    duty = forward_speed_reg;
            obav_pkg::CMD_REV:    duty = reverse_speed_reg;
            obav_pkg::CMD_SPIN_L: duty = turn_speed_reg;
            obav_pkg::CMD_SPIN_R: duty = turn_speed_reg;
            default:              duty = '0;
        endcase

        out_data_next.motor_command = motor_next;
        out_data_next.motor_speed   = duty;
        out_data_next.pan_angle     = pan_next;
        out_data_next.nav_mode      = mode_next;
        out_data_next.center_used   = center_used;
        out_data_next.sides_used    = sides_used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_distance_reg   <= obav_pkg::RST_SAFE_DISTANCE;
            scan_period_reg     <= obav_pkg::RST_SCAN_PERIOD;
            turn_duration_reg   <= obav_pkg::RST_TURN_DURATION;
            backup_duration_reg <= obav_pkg::RST_BACKUP_DURATION;
            forward_speed_reg   <= obav_pkg::RST_FORWARD_SPEED;
            turn_speed_reg      <= obav_pkg::RST_TURN_SPEED;
            reverse_speed_reg   <= obav_pkg::RST_REVERSE_SPEED;
            blocked_limit_reg   <= obav_pkg::RST_BLOCKED_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                obav_pkg::REG_SAFE_DISTANCE:
                    safe_distance_reg <= cfg_data[obav_pkg::DIST_W-1:0];
                obav_pkg::REG_SCAN_PERIOD:
                    scan_period_reg <= cfg_data;
                obav_pkg::REG_TURN_DURATION:
                    turn_duration_reg <= cfg_data;
                obav_pkg::REG_BACKUP_DURATION:
                    backup_duration_reg <= cfg_data;
                obav_pkg::REG_FORWARD_SPEED:
                    forward_speed_reg <= cfg_data[obav_pkg::DUTY_W-1:0];
                obav_pkg::REG_TURN_SPEED:
                    turn_speed_reg <= cfg_data[obav_pkg::DUTY_W-1:0];
                obav_pkg::REG_REVERSE_SPEED:
                    reverse_speed_reg <= cfg_data[obav_pkg::DUTY_W-1:0];
                obav_pkg::REG_BLOCKED_LIMIT:
                    blocked_limit_reg <= cfg_data[obav_pkg::CNT_W-1:0];
                default:
                    blocked_limit_reg <= blocked_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FWD;
            last_scan_reg   <= '0;
            mode_start_reg  <= '0;
            turn_left_reg   <= 1'b0;
            blocked_cnt_reg <= '0;
            motor_reg       <= obav_pkg::CMD_STOP;
            pan_reg         <= obav_pkg::ANGLE_CENTER;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (step)
            begin
                mode_reg        <= mode_next;
                last_scan_reg   <= last_scan_next;
                mode_start_reg  <= mode_start_next;
                turn_left_reg   <= turn_left_next;
                blocked_cnt_reg <= blocked_cnt_next;
                motor_reg       <= motor_next;
                pan_reg         <= pan_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_data_reg <= sample;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // avoid mode always holds the stop command
    a_avoid_stops: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.nav_mode == MODE_AVD |->
            result.motor_command == obav_pkg::CMD_STOP && result.motor_speed == '0)
        else $error("avoid mode result without stopped motors");

    // side distances are read only on the avoid step, which leads into turn
    a_sides_turn: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sides_used |->
            result.nav_mode == MODE_TRN && !result.center_used &&
            result.pan_angle == obav_pkg::ANGLE_RIGHT)
        else $error("side distances used outside the avoid step");

    // a consumed center reading leaves the pan centered
    a_center_pan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.center_used |-> result.pan_angle == obav_pkg::ANGLE_CENTER)
        else $error("center reading without centered pan");

    // recovery always clears the blocked counter on entry
    a_rec_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg != MODE_REC && mode_next == MODE_REC |=> blocked_cnt_reg == '0)
        else $error("blocked count not cleared on recovery entry");

    // a held result is not lost when the input register fills behind it
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

// ===== tb/obstacle_avoid_navigator_tb.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_navigator_tb - self-checking bench for the navigator
// Drives control-loop samples over a valid/ready channel and predicts each
// result with a behavioral copy of the mode machine and stuck check. Runs a
// directed walk through every mode and the time wrap, then random samples
// under several register settings and receiver/sender stall mixes.
// ----------------------------------------------------------------------------
module obstacle_avoid_navigator_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [obav_pkg::MODE_W-1:0] {
        NAV_FORWARD = 2'd0,
        NAV_AVOID   = 2'd1,
        NAV_TURN    = 2'd2,
        NAV_RECOVER = 2'd3
    } nav_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            sample_valid = 1'b0;
    logic                            sample_ready;
    obav_pkg::sample_t               sample = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    obav_pkg::result_t               result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [obav_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [obav_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    obstacle_avoid_navigator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // register copy
    logic [obav_pkg::DIST_W-1:0] safe_dist_q;
    logic [obav_pkg::DUR_W-1:0]  scan_per_q;
    logic [obav_pkg::DUR_W-1:0]  turn_dur_q;
    logic [obav_pkg::DUR_W-1:0]  backup_dur_q;
    logic [obav_pkg::DUTY_W-1:0] fwd_duty_q;
    logic [obav_pkg::DUTY_W-1:0] turn_duty_q;
    logic [obav_pkg::DUTY_W-1:0] rev_duty_q;
    logic [obav_pkg::CNT_W-1:0]  blk_limit_q;

    // navigation state copy
    nav_mode_t                   nav_q;
    logic [obav_pkg::TIME_W-1:0] scan_time_q;
    logic [obav_pkg::TIME_W-1:0] start_time_q;
    logic                        turn_left_q;
    logic [obav_pkg::CNT_W-1:0]  blocked_q;
    logic [obav_pkg::CMD_W-1:0]  motor_q;
    logic [obav_pkg::PAN_W-1:0]  pan_q;

    obav_pkg::sample_t           pending_samples[$];
    obav_pkg::result_t           expected_results[$];
    int                          samples_queued = 0;
    int                          samples_sent = 0;
    int                          results_seen = 0;
    int                          error_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    logic                        hold_off = 1'b0;
    int                          cycle_count = 0;
    logic [obav_pkg::TIME_W-1:0] clock_ms = '0;

    function automatic logic [obav_pkg::TIME_W-1:0] ms_since(
        logic [obav_pkg::TIME_W-1:0] now, logic [obav_pkg::TIME_W-1:0] since);
        return now - since;
    endfunction

    // one control-loop iteration on the state copy
    function automatic obav_pkg::result_t advance_navigator(obav_pkg::sample_t s);
        obav_pkg::result_t r;
        logic              c_used;
        logic              s_used;
        c_used = 1'b0;
        s_used = 1'b0;
        unique case (nav_q)
            NAV_FORWARD:
            begin
                motor_q = obav_pkg::CMD_FWD;
                if (ms_since(s.time_ms, scan_time_q) >= scan_per_q)
                begin
                    scan_time_q = s.time_ms;
                    pan_q = obav_pkg::ANGLE_CENTER;
                    c_used = 1'b1;
                    if (s.center_cm < safe_dist_q)
                    begin
                        nav_q = NAV_AVOID;
                        start_time_q = s.time_ms;
                        motor_q = obav_pkg::CMD_STOP;
                    end
                end
            end
            NAV_AVOID:
            begin
                // the left look is overwritten by the right look at once
                pan_q = obav_pkg::ANGLE_RIGHT;
                s_used = 1'b1;
                turn_left_q = (s.left_cm >= s.right_cm);
                nav_q = NAV_TURN;
                start_time_q = s.time_ms;
            end
            NAV_TURN:
            begin
                motor_q = turn_left_q ? obav_pkg::CMD_SPIN_L : obav_pkg::CMD_SPIN_R;
                if (ms_since(s.time_ms, start_time_q) >= turn_dur_q)
                begin
                    nav_q = NAV_FORWARD;
                    start_time_q = s.time_ms;
                    pan_q = obav_pkg::ANGLE_CENTER;
                end
            end
            default:
            begin
                motor_q = obav_pkg::CMD_REV;
                if (ms_since(s.time_ms, start_time_q) >= backup_dur_q)
                begin
                    nav_q = NAV_FORWARD;
                    start_time_q = s.time_ms;
                end
            end
        endcase

        // stuck check, only reachable on re-entry to forward unless scan period is zero
        if (nav_q == NAV_FORWARD && ms_since(s.time_ms, scan_time_q) >= scan_per_q)
        begin
            scan_time_q = s.time_ms;
            pan_q = obav_pkg::ANGLE_CENTER;
            c_used = 1'b1;
            if (s.center_cm < safe_dist_q)
            begin
                if (blocked_q != obav_pkg::CNT_MAX)
                    blocked_q = blocked_q + 1'b1;
                if (blocked_q >= blk_limit_q)
                begin
                    nav_q = NAV_RECOVER;
                    start_time_q = s.time_ms;
                    blocked_q = '0;
                end
            end
            else if (blocked_q != '0)
            begin
                blocked_q = blocked_q - 1'b1;
            end
        end

        r.motor_command = motor_q;
        unique case (motor_q)
            obav_pkg::CMD_FWD:    r.motor_speed = fwd_duty_q;
            obav_pkg::CMD_REV:    r.motor_speed = rev_duty_q;
            obav_pkg::CMD_SPIN_L: r.motor_speed = turn_duty_q;
            obav_pkg::CMD_SPIN_R: r.motor_speed = turn_duty_q;
            default:              r.motor_speed = '0;
        endcase
        r.pan_angle   = pan_q;
        r.nav_mode    = nav_q;
        r.center_used = c_used;
        r.sides_used  = s_used;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at result %0d, %s: got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    task automatic queue_sample(logic [obav_pkg::TIME_W-1:0] t,
                                logic [obav_pkg::DIST_W-1:0] c,
                                logic [obav_pkg::DIST_W-1:0] l,
                                logic [obav_pkg::DIST_W-1:0] r);
        obav_pkg::sample_t s;
        s.time_ms   = t;
        s.center_cm = c;
        s.left_cm   = l;
        s.right_cm  = r;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(logic [obav_pkg::CFG_IDX_W-1:0] idx,
                             logic [obav_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        unique case (idx)
            obav_pkg::REG_SAFE_DISTANCE:   safe_dist_q  = data[obav_pkg::DIST_W-1:0];
            obav_pkg::REG_SCAN_PERIOD:     scan_per_q   = data[obav_pkg::DUR_W-1:0];
            obav_pkg::REG_TURN_DURATION:   turn_dur_q   = data[obav_pkg::DUR_W-1:0];
            obav_pkg::REG_BACKUP_DURATION: backup_dur_q = data[obav_pkg::DUR_W-1:0];
            obav_pkg::REG_FORWARD_SPEED:   fwd_duty_q   = data[obav_pkg::DUTY_W-1:0];
            obav_pkg::REG_TURN_SPEED:      turn_duty_q  = data[obav_pkg::DUTY_W-1:0];
            obav_pkg::REG_REVERSE_SPEED:   rev_duty_q   = data[obav_pkg::DUTY_W-1:0];
            default:                       blk_limit_q  = data[obav_pkg::CNT_W-1:0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic program_registers(logic [15:0] safe, logic [15:0] scan,
                                     logic [15:0] turn, logic [15:0] backup,
                                     logic [15:0] fwd, logic [15:0] spin,
                                     logic [15:0] rev, logic [15:0] limit);
        write_reg(obav_pkg::REG_SAFE_DISTANCE, safe);
        write_reg(obav_pkg::REG_SCAN_PERIOD, scan);
        write_reg(obav_pkg::REG_TURN_DURATION, turn);
        write_reg(obav_pkg::REG_BACKUP_DURATION, backup);
        write_reg(obav_pkg::REG_FORWARD_SPEED, fwd);
        write_reg(obav_pkg::REG_TURN_SPEED, spin);
        write_reg(obav_pkg::REG_REVERSE_SPEED, rev);
        write_reg(obav_pkg::REG_BLOCKED_LIMIT, limit);
    endtask

    task automatic wait_drained();
        while (samples_sent != samples_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // timestamps mostly advance at a pace matched to the current durations
    task automatic queue_random_samples(int count);
        int                          span;
        int                          roll;
        logic [obav_pkg::DIST_W-1:0] c;
        logic [obav_pkg::DIST_W-1:0] l;
        logic [obav_pkg::DIST_W-1:0] r;
        span = int'(scan_per_q);
        if (turn_dur_q > span)
            span = int'(turn_dur_q);
        if (backup_dur_q > span)
            span = int'(backup_dur_q);
        span = span / 3 + 4;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                clock_ms = $urandom();
            else if (roll < 8)
                clock_ms = clock_ms - $urandom_range(0, 1000);
            else
                clock_ms = clock_ms + $urandom_range(0, span);

            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                case ($urandom_range(0, 2))
                    0:       c = '0;
                    1:       c = 10'd999;
                    default: c = '1;
                endcase
            end
            else if (roll < 55 && safe_dist_q != '0)
                c = 10'($urandom_range(0, safe_dist_q - 1));
            else
                c = 10'($urandom_range(0, 1023));

            l = 10'($urandom_range(0, 1023));
            r = ($urandom_range(0, 99) < 15) ? l : 10'($urandom_range(0, 1023));
            queue_sample(clock_ms, c, l, r);
        end
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                expected_results.push_back(advance_navigator(sample));
                samples_sent++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_samples.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        obav_pkg::result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction", 32'(result), 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.motor_command !== want.motor_command)
                        report_mismatch("motor_command", 32'(result.motor_command),
                                        32'(want.motor_command));
                    if (result.motor_speed !== want.motor_speed)
                        report_mismatch("motor_speed", 32'(result.motor_speed),
                                        32'(want.motor_speed));
                    if (result.pan_angle !== want.pan_angle)
                        report_mismatch("pan_angle", 32'(result.pan_angle),
                                        32'(want.pan_angle));
                    if (result.nav_mode !== want.nav_mode)
                        report_mismatch("nav_mode", 32'(result.nav_mode),
                                        32'(want.nav_mode));
                    if (result.center_used !== want.center_used)
                        report_mismatch("center_used", 32'(result.center_used),
                                        32'(want.center_used));
                    if (result.sides_used !== want.sides_used)
                        report_mismatch("sides_used", 32'(result.sides_used),
                                        32'(want.sides_used));
                end
            end
            result_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver stall while the sender keeps offering, fills the pipe
    initial
    begin
        wait (samples_sent >= 100);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("obstacle_avoid_navigator verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        safe_dist_q  = obav_pkg::RST_SAFE_DISTANCE;
        scan_per_q   = obav_pkg::RST_SCAN_PERIOD;
        turn_dur_q   = obav_pkg::RST_TURN_DURATION;
        backup_dur_q = obav_pkg::RST_BACKUP_DURATION;
        fwd_duty_q   = obav_pkg::RST_FORWARD_SPEED;
        turn_duty_q  = obav_pkg::RST_TURN_SPEED;
        rev_duty_q   = obav_pkg::RST_REVERSE_SPEED;
        blk_limit_q  = obav_pkg::RST_BLOCKED_LIMIT;
        nav_q        = NAV_FORWARD;
        scan_time_q  = '0;
        start_time_q = '0;
        turn_left_q  = 1'b0;
        blocked_q    = '0;
        motor_q      = obav_pkg::CMD_STOP;
        pan_q        = obav_pkg::ANGLE_CENTER;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 84;

        // walk through every mode on reset settings
        queue_sample(32'd0, 10'd999, 10'd999, 10'd999);
        queue_sample(32'd400, 10'd5, 10'd0, 10'd0);        // blocked center, enter avoid
        queue_sample(32'd401, 10'd0, 10'd500, 10'd500);    // equal sides turn left
        queue_sample(32'd600, 10'd0, 10'd0, 10'd0);
        queue_sample(32'd851, 10'd0, 10'd0, 10'd0);        // turn ends, stuck check blocked
        queue_sample(32'd852, 10'd1023, 10'd0, 10'd0);
        queue_sample(32'd1251, 10'd21, 10'd0, 10'd0);
        queue_sample(32'd1260, 10'd0, 10'd0, 10'd1023);    // turn right
        queue_sample(32'd1710, 10'd10, 10'd0, 10'd0);
        queue_sample(32'd2110, 10'd22, 10'd0, 10'd0);      // exactly safe distance is clear
        queue_sample(32'd2510, 10'd0, 10'd0, 10'd0);
        queue_sample(32'd2511, 10'd0, 10'd1023, 10'd1022);
        queue_sample(32'd2961, 10'd0, 10'd0, 10'd0);       // third blocked count, recover
        queue_sample(32'd3000, 10'd999, 10'd0, 10'd0);
        queue_sample(32'd3311, 10'd999, 10'd0, 10'd0);     // backup ends, keeps reverse
        queue_sample(32'd3312, 10'd999, 10'd0, 10'd0);
        queue_sample(32'hFFFF_FF00, 10'd999, 10'd0, 10'd0);
        queue_sample(32'h0000_0090, 10'd999, 10'd0, 10'd0); // scan across the time wrap
        queue_sample(32'hFFFF_FFFF, 10'd0, 10'd1023, 10'd1023);
        queue_sample(32'd0, 10'd0, 10'd1023, 10'd0);
        queue_sample(32'd449, 10'd1023, 10'd0, 10'd1023);
        queue_sample(32'd450, 10'd1023, 10'd0, 10'd1023);
        wait_drained();

        for (int k = 0; k < 7; k++)
        begin
            if (k == 2)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end
            if (k == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                0: program_registers(16'(obav_pkg::RST_SAFE_DISTANCE),
                                     obav_pkg::RST_SCAN_PERIOD,
                                     obav_pkg::RST_TURN_DURATION,
                                     obav_pkg::RST_BACKUP_DURATION,
                                     16'(obav_pkg::RST_FORWARD_SPEED),
                                     16'(obav_pkg::RST_TURN_SPEED),
                                     16'(obav_pkg::RST_REVERSE_SPEED),
                                     16'(obav_pkg::RST_BLOCKED_LIMIT));
                // blocked unless the center reads 1023, zero periods, zero limit
                1: program_registers(16'd1023, 16'd0, 16'd0, 16'd0,
                                     16'd0, 16'd0, 16'd0, 16'd0);
                // never blocked, longest periods
                2: program_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'd255, 16'd255, 16'd255, 16'd15);
                3: program_registers(16'd999, 16'd1, 16'd1, 16'd1,
                                     16'd1, 16'd254, 16'd128, 16'd1);
                // raw 16-bit data, narrow registers drop the upper bits
                default: program_registers(16'($urandom_range(0, 65535)),
                                           16'($urandom_range(0, 2000)),
                                           16'($urandom_range(0, 2000)),
                                           16'($urandom_range(0, 2000)),
                                           16'($urandom_range(0, 65535)),
                                           16'($urandom_range(0, 65535)),
                                           16'($urandom_range(0, 65535)),
                                           16'($urandom_range(0, 65535)));
            endcase
            queue_random_samples(200);
            wait_drained();
        end

        if (error_count == 0)
            $display("obstacle_avoid_navigator verification clean");
        else
            $display("obstacle_avoid_navigator verification failed");
        $finish;
    end

endmodule
